// File: rtl/slxfr_pkg.sv
// Shared constants and types for the sync/length/xor frame receiver.
package slxfr_pkg;

	localparam int MAX_PAYLOAD = 20;
	localparam int STATE_BYTES = 12;

	localparam logic [7:0] SYNC_BYTE = 8'hA5;

	localparam int BYTE_W     = 8;
	localparam int EV_W       = 3;
	localparam int IDX_W      = 4;
	localparam int TICK_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int POS_W  = $clog2(MAX_PAYLOAD + 4);

	localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
	localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEN  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_DATA = POS_W'(3);

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE    = 1'd1;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;
	localparam logic [BYTE_W-1:0] TYPE_RST    = 8'd83;

	typedef enum logic [EV_W-1:0] {
		EV_NONE    = 3'd0,
		EV_STATE   = 3'd1,
		EV_BADSUM  = 3'd2,
		EV_TOOLONG = 3'd3,
		EV_OTHER   = 3'd4
	} ev_t;

	typedef struct packed {
		logic tick;
		logic restart;
	} tmr_ctl_t;

	typedef struct packed {
		logic relay_now;
		logic relay_next;
	} tmr_stat_t;

endpackage

// File: rtl/slxfr_if.sv
// Valid/ready channel interfaces for input items and result beats.
interface slxfr_in_if import slxfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface slxfr_out_if import slxfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic              relay_on;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] byte_value;
	logic              last;

	modport source (output valid, output event_res, output relay_on, output byte_index,
		output byte_value, output last, input ready);
	modport sink (input valid, input event_res, input relay_on, input byte_index,
		input byte_value, input last, output ready);
endinterface

// File: rtl/slxfr_ram.sv
// Simple dual-port RAM with registered read data.
module slxfr_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 20,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/slxfr_timer.sv
// Saturating activity timer and relay-active flag.
module slxfr_timer import slxfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tmr_ctl_t          ctl,
	input  logic [TICK_W-1:0] timeout,
	output tmr_stat_t         stat
);

	logic [TICK_W-1:0] elapsed_q;
	logic [TICK_W-1:0] elapsed_d;
	logic              heard_q;
	logic              heard_d;

	always_comb begin
		elapsed_d = elapsed_q;
		heard_d   = heard_q;
		if (ctl.restart) begin
			elapsed_d = '0;
			heard_d   = 1'b1;
		end else if (ctl.tick && elapsed_q != '1) begin
			elapsed_d = elapsed_q + TICK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			heard_q   <= 1'b0;
		end else begin
			elapsed_q <= elapsed_d;
			heard_q   <= heard_d;
		end
	end

	assign stat.relay_now  = heard_q && (elapsed_q < timeout);
	assign stat.relay_next = heard_d && (elapsed_d < timeout);

endmodule

// File: rtl/sync_length_xor_frame_receiver.sv
// Top level of the sync/type/length/xor frame receiver.
//
// Input channel in_ch carries one item per beat: a received serial byte
// (action 0) or a one-tick timer event (action 1). Output channel out_ch
// carries result beats: event code, relay flag, state byte index and value,
// and last on the final beat caused by an item.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
// index 0 sets the timeout in ticks, index 1 the accepted frame type.
// A tick or a byte that does not complete a good state frame yields one
// beat, registered in the cycle after the item is taken; the next item may
// be taken in the cycle the beat leaves. A good state frame yields twelve
// beats read back from the payload RAM: for each beat a read state issues
// the RAM read and a load state then registers the beat, waiting while the
// output register is full. No item is taken until the last beat is loaded.
// Reset clears the parser to sync hunt, the timer and flag, and loads the
// register defaults; RAM contents are not cleared. When the sink stalls,
// the output register holds its beat and the input stops taking items.
module sync_length_xor_frame_receiver import slxfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	slxfr_in_if.sink              in_ch,
	slxfr_out_if.source           out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_LD
	} state_t;

	state_t state_q;

	logic [TICK_W-1:0] timeout_q;
	logic [BYTE_W-1:0] acc_type_q;

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [BYTE_W-1:0] type_q, type_d;

	logic [ADDR_W-1:0] cnt_q;

	logic              oval_q;
	ev_t               oev_q;
	logic              orelay_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              olast_q;

	logic              out_free;
	logic              in_acc;
	logic              byte_acc;
	logic              frame_ok;
	ev_t               ev;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_rdata;
	tmr_ctl_t          tctl;
	tmr_stat_t         tstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			acc_type_q <= TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q  <= cfg_data;
				CFG_TYPE:    acc_type_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free    = !oval_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign byte_acc    = in_acc && !in_ch.action;

	always_comb begin
		pos_d     = pos_q;
		len_d     = len_q;
		xor_d     = xor_q;
		type_d    = type_q;
		ev        = EV_NONE;
		frame_ok  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(pos_q - POS_DATA);
		if (byte_acc) begin
			if (pos_q == POS_HUNT) begin
				if (in_ch.rx_byte == SYNC_BYTE) begin
					pos_d = POS_TYPE;
					len_d = '0;
					xor_d = '0;
				end
			end else if (pos_q == POS_TYPE) begin
				type_d = in_ch.rx_byte;
				xor_d  = in_ch.rx_byte;
				pos_d  = POS_LEN;
			end else if (pos_q == POS_LEN) begin
				if (in_ch.rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
					ev    = EV_TOOLONG;
					pos_d = POS_HUNT;
				end else begin
					len_d = LEN_W'(in_ch.rx_byte);
					xor_d = xor_q ^ in_ch.rx_byte;
					pos_d = POS_DATA;
				end
			end else if (pos_q < POS_W'(len_q) + POS_DATA) begin
				ram_we = 1'b1;
				xor_d  = xor_q ^ in_ch.rx_byte;
				pos_d  = pos_q + POS_W'(1);
			end else begin
				pos_d = POS_HUNT;
				if (xor_q != in_ch.rx_byte) begin
					ev = EV_BADSUM;
				end else if (type_q != acc_type_q || len_q != LEN_W'(STATE_BYTES)) begin
					ev = EV_OTHER;
				end else begin
					ev       = EV_STATE;
					frame_ok = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			len_q  <= '0;
			xor_q  <= '0;
			type_q <= '0;
		end else begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			xor_q  <= xor_d;
			type_q <= type_d;
		end
	end

	assign tctl.tick    = in_acc && in_ch.action;
	assign tctl.restart = frame_ok;

	slxfr_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tctl),
		.timeout (timeout_q),
		.stat    (tstat)
	);

	slxfr_ram #(
		.DATA_W (BYTE_W),
		.DEPTH  (MAX_PAYLOAD),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_ch.rx_byte),
		.re    (state_q == ST_RD),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			oval_q   <= 1'b0;
			oev_q    <= EV_NONE;
			orelay_q <= 1'b0;
			oidx_q   <= '0;
			obyte_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (frame_ok) begin
							cnt_q   <= '0;
							state_q <= ST_RD;
						end else begin
							oval_q   <= 1'b1;
							oev_q    <= ev;
							orelay_q <= tstat.relay_next;
							oidx_q   <= '0;
							obyte_q  <= '0;
							olast_q  <= 1'b1;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (out_free) begin
						oval_q   <= 1'b1;
						oev_q    <= EV_STATE;
						orelay_q <= tstat.relay_now;
						oidx_q   <= IDX_W'(cnt_q);
						obyte_q  <= ram_rdata;
						olast_q  <= (cnt_q == ADDR_W'(STATE_BYTES - 1));
						if (cnt_q == ADDR_W'(STATE_BYTES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + ADDR_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = oval_q;
	assign out_ch.event_res  = oev_q;
	assign out_ch.relay_on   = orelay_q;
	assign out_ch.byte_index = oidx_q;
	assign out_ch.byte_value = obyte_q;
	assign out_ch.last       = olast_q;

	a_state_last: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && oev_q == EV_STATE |-> olast_q == (oidx_q == IDX_W'(STATE_BYTES - 1)))
		else $error("state beat last flag out of step with index");

	a_other_clean: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && oev_q != EV_STATE |-> olast_q && oidx_q == '0 && obyte_q == '0)
		else $error("non-state beat carries index, value or misses last");

	a_emit_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> pos_q == POS_HUNT)
		else $error("parser not hunting while frame bytes are emitted");

	a_emit_relay: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && oev_q == EV_STATE |-> orelay_q == (timeout_q != '0))
		else $error("relay flag wrong on state beat");

	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && in_acc && frame_ok |=> state_q == ST_RD && cnt_q == '0)
		else $error("accepted frame did not start readback at entry zero");

endmodule

// File: sim/slxfr_checker.sv
// Result checker for the frame receiver: tracks the deframing state, predicts beats, compares.
`timescale 1ns / 1ps

module slxfr_checker import slxfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	slxfr_in_if                   in_mon,
	slxfr_out_if                  out_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    beats_due
);

	typedef struct packed {
		ev_t               ev;
		logic              relay;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] val;
		logic              last;
	} beat_t;

	beat_t results_due[$];

	logic [TICK_W-1:0] timeout_reg;
	logic [BYTE_W-1:0] type_reg;

	int unsigned       frame_pos;
	int unsigned       frame_len;
	logic [BYTE_W-1:0] frame_xor;
	logic [BYTE_W-1:0] frame_kind;
	logic [BYTE_W-1:0] frame_body [MAX_PAYLOAD];
	logic [TICK_W-1:0] ticks_since;
	logic              frame_heard;

	function automatic void queue_beat(input ev_t ev, input int idx, input logic [BYTE_W-1:0] val,
		input logic fin);
		beat_t b;
		b.ev    = ev;
		b.relay = frame_heard && (ticks_since < timeout_reg);
		b.idx   = IDX_W'(idx);
		b.val   = val;
		b.last  = fin;
		results_due.push_back(b);
	endfunction

	function automatic void deframe_item(input logic act, input logic [BYTE_W-1:0] b);
		ev_t ev;
		ev = EV_NONE;
		if (act) begin
			if (ticks_since != '1)
				ticks_since++;
			queue_beat(EV_NONE, 0, '0, 1'b1);
			return;
		end
		if (frame_pos == 0) begin
			if (b == SYNC_BYTE) begin
				frame_pos = 1;
				frame_len = 0;
				frame_xor = '0;
			end
		end else if (frame_pos == 1) begin
			frame_kind = b;
			frame_xor  = b;
			frame_pos  = 2;
		end else if (frame_pos == 2) begin
			if (b > MAX_PAYLOAD) begin
				ev        = EV_TOOLONG;
				frame_pos = 0;
			end else begin
				frame_len = b;
				frame_xor ^= b;
				frame_pos = 3;
			end
		end else if (frame_pos < frame_len + 3) begin
			frame_body[frame_pos - 3] = b;
			frame_xor ^= b;
			frame_pos++;
		end else begin
			frame_pos = 0;
			if (frame_xor != b) begin
				ev = EV_BADSUM;
			end else if (frame_kind != type_reg || frame_len != STATE_BYTES) begin
				ev = EV_OTHER;
			end else begin
				ticks_since = '0;
				frame_heard = 1'b1;
				for (int k = 0; k < STATE_BYTES; k++)
					queue_beat(EV_STATE, k, frame_body[k], k == STATE_BYTES - 1);
				return;
			end
		end
		queue_beat(ev, 0, '0, 1'b1);
	endfunction

	function automatic void match_beat(input beat_t got);
		beat_t want;
		if (results_due.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected beat: ev=%0d relay=%0b idx=%0d val=%02h last=%0b",
				$time, got.ev, got.relay, got.idx, got.val, got.last);
			return;
		end
		want = results_due.pop_front();
		if (got.ev !== want.ev || got.relay !== want.relay || got.idx !== want.idx ||
			got.val !== want.val || got.last !== want.last) begin
			fail_count++;
			$display("%0t: mismatch: expected %0d/%0b/%0d/%02h/%0b, got %0d/%0b/%0d/%02h/%0b",
				$time, want.ev, want.relay, want.idx, want.val, want.last,
				got.ev, got.relay, got.idx, got.val, got.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		beat_t got;
		if (!arst_n) begin
			timeout_reg = TIMEOUT_RST;
			type_reg    = TYPE_RST;
			frame_pos   = 0;
			frame_len   = 0;
			frame_xor   = '0;
			frame_kind  = '0;
			ticks_since = '0;
			frame_heard = 1'b0;
			results_due.delete();
			fail_count  = 0;
			beats_due   = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got.ev    = ev_t'(out_mon.event_res);
				got.relay = out_mon.relay_on;
				got.idx   = out_mon.byte_index;
				got.val   = out_mon.byte_value;
				got.last  = out_mon.last;
				match_beat(got);
			end
			if (in_mon.valid && in_mon.ready)
				deframe_item(in_mon.action, in_mon.rx_byte);
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT: timeout_reg = cfg_data[TICK_W-1:0];
					CFG_TYPE:    type_reg    = cfg_data[BYTE_W-1:0];
					default:     ;
				endcase
			end
			beats_due = results_due.size();
		end
	end

endmodule

// File: sim/tb_sync_length_xor_frame_receiver.sv
// Testbench top for the frame receiver: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sync_length_xor_frame_receiver;
	import slxfr_pkg::*;

	typedef logic [BYTE_W-1:0] byte_q_t[$];

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 32;
	localparam int TAIL_CYCLES  = 30;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int beats_due;
	int snd_idle_pct;
	int rcv_idle_pct;
	int tick_pct;
	int items_sent;
	int hold_left;
	int quiet_cycles;
	bit hold_req;
	logic [BYTE_W-1:0] cur_type;

	slxfr_in_if  in_ch ();
	slxfr_out_if out_ch ();

	sync_length_xor_frame_receiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	slxfr_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.beats_due  (beats_due)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic offer(input logic act, input logic [BYTE_W-1:0] b);
		if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_ch.valid   <= 1'b1;
		in_ch.action  <= act;
		in_ch.rx_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic maybe_tick();
		if (tick_pct != 0 && $urandom_range(99) < tick_pct)
			offer(1'b1, 8'($urandom));
	endtask

	function automatic byte_q_t rand_body(input int n);
		byte_q_t q;
		for (int i = 0; i < n; i++)
			q.push_back(8'($urandom));
		return q;
	endfunction

	task automatic send_frame(input logic [BYTE_W-1:0] kind, input logic [BYTE_W-1:0] len_byte,
		input byte_q_t body, input bit bad_sum);
		logic [BYTE_W-1:0] sum;
		offer(1'b0, SYNC_BYTE);
		maybe_tick();
		offer(1'b0, kind);
		offer(1'b0, len_byte);
		sum = kind ^ len_byte;
		foreach (body[i]) begin
			offer(1'b0, body[i]);
			sum ^= body[i];
			maybe_tick();
		end
		if (bad_sum)
			sum ^= 8'($urandom_range(1, 255));
		offer(1'b0, sum);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (beats_due != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [TICK_W-1:0] timeout, input logic [CFG_DATA_W-1:0] kind);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= CFG_DATA_W'(timeout);
		@(posedge clk);
		cfg_index <= CFG_TYPE;
		cfg_data  <= kind;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_type = kind[BYTE_W-1:0];
	endtask

	task automatic run_random(input int n);
		int start;
		int sel;
		int len;
		start = items_sent;
		while (items_sent - start < n) begin
			sel = $urandom_range(99);
			len = $urandom_range(MAX_PAYLOAD);
			if (sel < 40) begin
				send_frame(cur_type, 8'(STATE_BYTES), rand_body(STATE_BYTES), 1'b0);
			end else if (sel < 50) begin
				send_frame(8'($urandom), 8'(STATE_BYTES), rand_body(STATE_BYTES), 1'b0);
			end else if (sel < 60) begin
				send_frame(cur_type, 8'(len), rand_body(len), 1'b0);
			end else if (sel < 68) begin
				send_frame(8'($urandom), 8'(len), rand_body(len), 1'b1);
			end else if (sel < 75) begin
				offer(1'b0, SYNC_BYTE);
				offer(1'b0, 8'($urandom));
				offer(1'b0, 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 6)) offer(1'b1, 8'($urandom));
			end else if (sel < 93) begin
				offer(1'b0, 8'($urandom));
			end else begin
				// cut a frame short; following items land inside it
				offer(1'b0, SYNC_BYTE);
				offer(1'b0, 8'($urandom));
				offer(1'b0, 8'(len));
				repeat ($urandom_range(len)) offer(1'b0, 8'($urandom));
			end
		end
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		byte_q_t body;
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.action  <= 1'b0;
		in_ch.rx_byte <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_TIMEOUT;
		cfg_data      <= '0;
		hold_req     = 1'b0;
		items_sent   = 0;
		tick_pct     = 0;
		snd_idle_pct = 16;
		rcv_idle_pct = 58;
		cur_type     = TYPE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting, a tick, a state frame with extreme payload bytes, an overlong length, then an empty frame
		offer(1'b0, 8'hFF);
		offer(1'b0, 8'h00);
		offer(1'b1, 8'hFF);
		body = rand_body(STATE_BYTES);
		body[0] = 8'h00;
		body[STATE_BYTES-1] = 8'hFF;
		send_frame(TYPE_RST, 8'(STATE_BYTES), body, 1'b0);
		offer(1'b0, SYNC_BYTE);
		offer(1'b0, 8'h00);
		offer(1'b0, 8'hFF);
		send_frame(TYPE_RST, 8'h00, rand_body(0), 1'b0);

		// hold the output while the input keeps offering
		hold_req = 1'b1;
		send_frame(TYPE_RST, 8'(STATE_BYTES), rand_body(STATE_BYTES), 1'b0);
		repeat (8) offer(1'b1, 8'($urandom));
		drain();

		tick_pct = 10;
		set_config(16'd2, {8'($urandom), 8'h00});
		run_random(RANDOM_ITEMS);
		drain();

		snd_idle_pct = 58;
		rcv_idle_pct = 16;
		set_config(16'd1, {8'($urandom), 8'hFF});
		run_random(RANDOM_ITEMS);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_config(16'd0, {8'($urandom), TYPE_RST});
		run_random(RANDOM_ITEMS);
		drain();

		set_config(16'($urandom_range(3, 9)), 16'($urandom));
		run_random(RANDOM_ITEMS);
		drain();

		// restart the relay twice under the widest timeout
		tick_pct = 0;
		set_config(16'hFFFF, {8'($urandom), TYPE_RST});
		send_frame(TYPE_RST, 8'(STATE_BYTES), rand_body(STATE_BYTES), 1'b0);
		repeat (3) offer(1'b1, 8'($urandom));
		send_frame(TYPE_RST, 8'(STATE_BYTES), rand_body(STATE_BYTES), 1'b0);
		repeat (3) offer(1'b1, 8'($urandom));
		drain();

		if (fail_count == 0 && beats_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/slxfr_pkg.sv
rtl/slxfr_if.sv
rtl/slxfr_ram.sv
rtl/slxfr_timer.sv
rtl/sync_length_xor_frame_receiver.sv
sim/slxfr_checker.sv
sim/tb_sync_length_xor_frame_receiver.sv
